// ===== design/bpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_pkg
// Shared constants and types for the bracket pair distance block.
// ----------------------------------------------------------------------------
package bpd_pkg;

    localparam int MAX_LEN_DEF = 1024;
    localparam int CHAR_W      = 8;
    localparam int DIST_W      = 11;

    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h28;
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h29;

    // per-column status of one bracket stack
    typedef struct packed {
        logic pop;  // a pair closes at this column
        logic err;  // close on empty or open on full
    } t_stack_stat;

endpackage : bpd_pkg
`default_nettype wire

// ===== design/bpd_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_if
// Valid/ready channels for column beats and distance results.
// ----------------------------------------------------------------------------
interface bpd_in_if;
    import bpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_a;
    logic [CHAR_W-1:0] char_b;
    logic              last;

    modport source (output valid, char_a, char_b, last, input ready);
    modport sink   (input valid, char_a, char_b, last, output ready);
endinterface : bpd_in_if

interface bpd_out_if;
    import bpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] distance;
    logic              bad_nesting;

    modport source (output valid, distance, bad_nesting, input ready);
    modport sink   (input valid, distance, bad_nesting, output ready);
endinterface : bpd_out_if
`default_nettype wire

// ===== design/bpd_stack.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_stack
// Stack of open-bracket columns for one structure, held in a synchronous
// memory. A pop reads the partner column into a register for the next stage.
// ----------------------------------------------------------------------------
module bpd_stack #(
    parameter int MAX_LEN = bpd_pkg::MAX_LEN_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic                            i_clear,
    input  wire logic [bpd_pkg::CHAR_W-1:0]      i_char,
    input  wire logic [$clog2(MAX_LEN+2)-1:0]    i_col,
    output bpd_pkg::t_stack_stat                 o_stat,
    output logic      [$clog2(MAX_LEN+2)-1:0]    o_left
);
    import bpd_pkg::*;

    localparam int DEPTH = MAX_LEN / 2;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(MAX_LEN + 2);

    logic [CW-1:0] mem [DEPTH];
    logic [DW-1:0] r_depth;
    logic [DW-1:0] n_depth;
    logic [DW-1:0] depth_dec;
    logic [CW-1:0] r_left;
    logic          is_open;
    logic          is_close;
    logic          full;
    logic          empty;
    logic          do_push;
    logic          do_pop;

    assign is_open   = (i_char == CH_OPEN);
    assign is_close  = (i_char == CH_CLOSE);
    assign full      = (r_depth >= DW'(DEPTH));
    assign empty     = (r_depth == '0);
    assign do_push   = i_accept && is_open && !full;
    assign do_pop    = i_accept && is_close && !empty;
    assign depth_dec = r_depth - DW'(1);

    assign o_stat.pop = is_close && !empty;
    assign o_stat.err = (is_open && full) || (is_close && empty);
    assign o_left     = r_left;

    always_comb begin
        n_depth = r_depth;
        if (do_push) begin
            n_depth = r_depth + DW'(1);
        end else if (do_pop) begin
            n_depth = depth_dec;
        end
    end

    // push writes the free slot, pop reads the top; never both in one column
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            mem[r_depth[AW-1:0]] <= i_col;
        end
        if (do_pop) begin
            r_left <= mem[depth_dec[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (i_accept) begin
            r_depth <= i_clear ? '0 : n_depth;
        end
    end

endmodule : bpd_stack
`default_nettype wire

// ===== design/bpd_merge.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_merge
// Second stage: compares the popped partner columns, accumulates the
// saturating distance and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module bpd_merge #(
    parameter int MAX_LEN = bpd_pkg::MAX_LEN_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic                         i_last,
    input  wire logic                         i_err,
    input  wire bpd_pkg::t_stack_stat         i_stat_a,
    input  wire bpd_pkg::t_stack_stat         i_stat_b,
    input  wire logic [$clog2(MAX_LEN+2)-1:0] i_left_a,
    input  wire logic [$clog2(MAX_LEN+2)-1:0] i_left_b,
    output logic                              o_ready,
    bpd_out_if.source                         o_out
);
    import bpd_pkg::*;

    localparam int TW = $clog2(MAX_LEN + 1);

    logic              r_s2_valid;
    logic              r_s2_last;
    logic              r_s2_err;
    logic              r_pa;
    logic              r_pb;
    logic [TW-1:0]     r_total;
    logic              r_out_valid;
    logic [DIST_W-1:0] r_dist;
    logic              r_bad;
    logic [1:0]        add;
    logic [TW:0]       sum;
    logic [TW-1:0]     sat;
    logic              s2_move;

    always_comb begin
        add = 2'd0;
        if (r_pa && r_pb) begin
            add = (i_left_a == i_left_b) ? 2'd0 : 2'd2;
        end else if (r_pa || r_pb) begin
            add = 2'd1;
        end
    end

    assign sum = {1'b0, r_total} + (TW+1)'(add);
    assign sat = (sum > (TW+1)'(MAX_LEN)) ? TW'(MAX_LEN) : sum[TW-1:0];

    // only a last beat needs the output slot; others always advance
    assign s2_move = r_s2_valid && (!r_s2_last || !r_out_valid || o_out.ready);
    assign o_ready = !r_s2_valid || s2_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid  <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_s2_valid <= i_accept;
            end
            if (s2_move) begin
                r_total <= r_s2_last ? '0 : sat;
            end
            if (s2_move && r_s2_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s2_last <= i_last;
            r_s2_err  <= i_err;
            r_pa      <= i_stat_a.pop;
            r_pb      <= i_stat_b.pop;
        end
        if (s2_move && r_s2_last) begin
            r_dist <= DIST_W'(sat);
            r_bad  <= r_s2_err;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.distance    = r_dist;
    assign o_out.bad_nesting = r_bad;

endmodule : bpd_merge
`default_nettype wire

// ===== design/bracket_pair_distance.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bracket_pair_distance
// Base-pair distance between two dot-bracket structures streamed side by side.
// ----------------------------------------------------------------------------
// One column beat is accepted every cycle while input ready is high. Each
// structure keeps its open columns in a MAX_LEN/2-entry synchronous memory; a
// close pops the partner column in the accept cycle, the pair compare happens
// in the next stage, and the result beat is then registered in the output
// register. Input ready drops only while a finished result waits in the
// output register and a second last column is queued behind it. The stack
// memories need no clearing pass: only entries below the current depth are
// read. Columns past MAX_LEN and stack overflow or underflow set bad_nesting.
// ----------------------------------------------------------------------------
module bracket_pair_distance #(
    parameter int MAX_LEN = bpd_pkg::MAX_LEN_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    bpd_in_if.sink    i_in,
    bpd_out_if.source o_out
);
    import bpd_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 2);

    logic        w_ready;
    logic        in_acc;
    logic [CW-1:0] r_col;
    logic        r_err;
    logic        col_err;
    logic        err_now;
    t_stack_stat stat_a;
    t_stack_stat stat_b;
    logic [CW-1:0] left_a;
    logic [CW-1:0] left_b;

    assign i_in.ready = w_ready;
    assign in_acc     = i_in.valid && w_ready;
    assign col_err    = (r_col > CW'(MAX_LEN));
    assign err_now    = r_err || col_err || stat_a.err || stat_b.err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= CW'(1);
            r_err <= 1'b0;
        end else if (in_acc) begin
            if (i_in.last) begin
                r_col <= CW'(1);
                r_err <= 1'b0;
            end else begin
                // hold at MAX_LEN + 1 once the stream runs long
                if (!col_err) begin
                    r_col <= r_col + CW'(1);
                end
                r_err <= err_now;
            end
        end
    end

    bpd_stack #(.MAX_LEN(MAX_LEN)) u_stack_a (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_clear  (i_in.last),
        .i_char   (i_in.char_a),
        .i_col    (r_col),
        .o_stat   (stat_a),
        .o_left   (left_a)
    );

    bpd_stack #(.MAX_LEN(MAX_LEN)) u_stack_b (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_clear  (i_in.last),
        .i_char   (i_in.char_b),
        .i_col    (r_col),
        .o_stat   (stat_b),
        .o_left   (left_b)
    );

    bpd_merge #(.MAX_LEN(MAX_LEN)) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_last   (i_in.last),
        .i_err    (err_now),
        .i_stat_a (stat_a),
        .i_stat_b (stat_b),
        .i_left_a (left_a),
        .i_left_b (left_b),
        .o_ready  (w_ready),
        .o_out    (o_out)
    );

endmodule : bracket_pair_distance
`default_nettype wire

// ===== design/bpd_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bpd_checker
// Port-level checks for bracket_pair_distance, bound to the top level.
// ----------------------------------------------------------------------------
module bpd_checker #(
    parameter int MAX_LEN = bpd_pkg::MAX_LEN_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       i_in_ready,
    input wire logic                       i_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [bpd_pkg::DIST_W-1:0] i_distance,
    input wire logic                       i_bad_nesting
);
    import bpd_pkg::*;

    // a stalled result beat stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result beat dropped while stalled");

    // a stalled result beat keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_distance) && $stable(i_bad_nesting))
        else $error("result payload changed while stalled");

    // input back-pressure only comes from a blocked result
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("column input stalled without output back-pressure");

    // distance saturates at MAX_LEN
    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (MAX_LEN > 2047) || (int'(i_distance) <= MAX_LEN))
        else $error("distance above MAX_LEN");

endmodule : bpd_checker

bind bracket_pair_distance bpd_checker #(.MAX_LEN(MAX_LEN)) u_bpd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_distance    (o_out.distance),
    .i_bad_nesting (o_out.bad_nesting)
);
`default_nettype wire
